// ----- src/spi_ms_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_ms_pkg
// shared types and codes for the spi master shift engine
// ----------------------------------------------------------------------------
package spi_ms_pkg;

  localparam int unsigned FRAME_BITS_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd2;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [2:0] DIVIDE_RESET = 3'd2;

  typedef struct packed {
    logic [2:0] divide_log2;
    logic [1:0] mode;
    logic       lsb_first;
  } cfg_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
  } res_t;

endpackage

// ----- src/spi_ms_cfg.sv -----
// ----------------------------------------------------------------------------
// spi_ms_cfg
// configuration registers: clock divide, spi mode and bit order
// ----------------------------------------------------------------------------
module spi_ms_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spi_ms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spi_ms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output spi_ms_pkg::cfg_t                  cfg_o
);

  spi_ms_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        spi_ms_pkg::CFG_DIVIDE: cfg_d.divide_log2 = cfg_data_i;
        spi_ms_pkg::CFG_MODE:   cfg_d.mode        = cfg_data_i[1:0];
        spi_ms_pkg::CFG_ORDER:  cfg_d.lsb_first   = cfg_data_i[0];
        default:                cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.divide_log2 <= spi_ms_pkg::DIVIDE_RESET;
      cfg_q.mode        <= 2'd0;
      cfg_q.lsb_first   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/spi_ms_core.sv -----
// ----------------------------------------------------------------------------
// spi_ms_core
// shift engine state: divider, edge counter, shift register and flags
// ----------------------------------------------------------------------------
module spi_ms_core #(
  parameter int unsigned FRAME_BITS = spi_ms_pkg::FRAME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       tx_byte_i,
  input  logic             miso_i,
  input  spi_ms_pkg::cfg_t cfg_i,
  output spi_ms_pkg::res_t res_o
);

  localparam int unsigned EC_W = $clog2(2 * FRAME_BITS + 1);
  localparam logic [EC_W-1:0] LAST_EDGE = EC_W'(2 * FRAME_BITS);

  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [FRAME_BITS-1:0] recv_q, recv_d;
  logic [EC_W-1:0]       edge_q, edge_d;
  logic [6:0]            div_q, div_d;
  logic                  level_q, level_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  latch_q, latch_d;

  logic [2:0]            k;
  logic [6:0]            half;
  logic [6:0]            div_inc;
  logic [EC_W-1:0]       edge_inc;
  logic                  leading;
  logic                  cpha;
  logic                  shift_en;
  logic [FRAME_BITS-1:0] shifted;
  logic [FRAME_BITS+7:0] tx_ext;
  logic [FRAME_BITS+7:0] rx_ext;

  assign cpha     = cfg_i.mode[0];
  assign k        = (cfg_i.divide_log2 == 3'd0) ? 3'd1 : cfg_i.divide_log2;
  assign half     = 7'd1 << (k - 3'd1);
  assign div_inc  = div_q + 7'd1;
  assign edge_inc = edge_q + EC_W'(1);
  assign leading  = edge_inc[0];
  assign tx_ext   = {{FRAME_BITS{1'b0}}, tx_byte_i};

  always_comb begin
    shift_d  = shift_q;
    recv_d   = recv_q;
    edge_d   = edge_q;
    div_d    = div_q;
    level_d  = level_q;
    busy_d   = busy_q;
    done_d   = done_q;
    latch_d  = latch_q;
    shift_en = 1'b0;
    shifted  = shift_q;

    case (req_type_i)
      spi_ms_pkg::REQ_TICK: begin
        if (busy_q) begin
          if (div_inc < half) begin
            div_d = div_inc;
          end else begin
            // serial clock edge
            div_d   = 7'd0;
            level_d = ~level_q;
            edge_d  = edge_inc;
            if (cpha == 1'b0) begin
              if (leading) latch_d = miso_i;
              else shift_en = 1'b1;
            end else begin
              if (leading) shift_en = (edge_inc > EC_W'(1));
              else latch_d = miso_i;
            end
            // cpha 1 takes the last sampled bit in when the frame ends
            if (edge_inc >= LAST_EDGE && cpha) shift_en = 1'b1;

            if (cfg_i.lsb_first) begin
              shifted = {latch_d, shift_q[FRAME_BITS-1:1]};
            end else begin
              shifted = {shift_q[FRAME_BITS-2:0], latch_d};
            end
            if (shift_en) shift_d = shifted;

            if (edge_inc >= LAST_EDGE) begin
              recv_d  = shift_d;
              done_d  = 1'b1;
              busy_d  = 1'b0;
              edge_d  = '0;
              div_d   = 7'd0;
              level_d = 1'b0;
            end
          end
        end
      end
      spi_ms_pkg::REQ_LOAD: begin
        if (!busy_q) begin
          shift_d = tx_ext[FRAME_BITS-1:0];
          busy_d  = 1'b1;
          edge_d  = '0;
          div_d   = 7'd0;
          level_d = 1'b0;
          latch_d = 1'b0;
        end
      end
      spi_ms_pkg::REQ_READ: done_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      recv_q  <= '0;
      edge_q  <= '0;
      div_q   <= 7'd0;
      level_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      latch_q <= 1'b0;
    end else if (step_i) begin
      shift_q <= shift_d;
      recv_q  <= recv_d;
      edge_q  <= edge_d;
      div_q   <= div_d;
      level_q <= level_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      latch_q <= latch_d;
    end
  end

  // result shows the state after this item
  assign rx_ext        = {8'd0, recv_d};
  assign res_o.sck     = level_d ^ cfg_i.mode[1];
  assign res_o.mosi    = cfg_i.lsb_first ? shift_d[0] : shift_d[FRAME_BITS-1];
  assign res_o.busy    = busy_d;
  assign res_o.done    = done_d;
  assign res_o.rx_byte = rx_ext[7:0];

endmodule

// ----- src/spi_ms_out_reg.sv -----
// ----------------------------------------------------------------------------
// spi_ms_out_reg
// result register with valid/ready handshake toward the consumer
// ----------------------------------------------------------------------------
module spi_ms_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  spi_ms_pkg::res_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             can_load_o,
  output spi_ms_pkg::res_t res_o
);

  logic             valid_q, valid_d;
  spi_ms_pkg::res_t res_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/spi_master_shifter_unit.sv -----
// ----------------------------------------------------------------------------
// spi_master_shifter_unit
// spi master shift engine, modes 0 to 3, one base-clock tick per item
// ----------------------------------------------------------------------------
// Each accepted item is one base tick, a load or a read; it gives one result
// holding sck, mosi, busy, done and the last received byte as they stand
// after that item. An item is taken every clock cycle unless a result waits
// unread: the next state and the result are formed in one pass of logic and
// land in the state and result registers at the same edge; a result that
// waits holds no item back if the result register is emptied in that cycle.
// Configuration (divide, mode, bit order) is written at a plain write port;
// the user is to write it while no item or result is in flight (not enforced
// by the block); a change takes effect at once, also in the middle of a byte.
module spi_master_shifter_unit #(
  parameter int unsigned FRAME_BITS = spi_ms_pkg::FRAME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spi_ms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spi_ms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [7:0]                        tx_byte_i,
  input  logic                              miso_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              sck_o,
  output logic                              mosi_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic [7:0]                        rx_byte_o
);

  spi_ms_pkg::cfg_t cfg;
  spi_ms_pkg::res_t res_next;
  spi_ms_pkg::res_t res_out;
  logic             can_load;
  logic             step;

  assign in_ready_o = can_load;
  assign step       = in_valid_i && can_load;

  spi_ms_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  spi_ms_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .req_type_i (req_type_i),
    .tx_byte_i  (tx_byte_i),
    .miso_i     (miso_i),
    .cfg_i      (cfg),
    .res_o      (res_next)
  );

  spi_ms_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_next),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .can_load_o  (can_load),
    .res_o       (res_out)
  );

  assign sck_o      = res_out.sck;
  assign mosi_o     = res_out.mosi;
  assign busy_res_o = res_out.busy;
  assign done_res_o = res_out.done;
  assign rx_byte_o  = res_out.rx_byte;

endmodule

// ----- sim/spi_master_shifter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// spi_master_shifter_unit_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the spi master shift engine. A queue of requests
// (base ticks, byte loads, flag reads and the unused code) feeds a valid/ready
// driver. Each transfer accepted on the request side is run through a local
// cycle model of the engine, and the pin state it should produce is queued.
// A monitor with random back-pressure checks every result transfer against
// the oldest queued state. Configuration changes are made between phases,
// once the engine has returned every result, and cover divides 0 to 4 and
// 7, all four spi modes and both bit orders.
// ----------------------------------------------------------------------------
module spi_master_shifter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned NBITS = spi_ms_pkg::FRAME_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] tx;
    logic       miso;
  } spi_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [spi_ms_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [spi_ms_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i = spi_ms_pkg::REQ_TICK;
  logic [7:0] tx_byte_i = '0;
  logic       miso_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       sck_o;
  logic       mosi_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;

  spi_master_shifter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .tx_byte_i  (tx_byte_i),
    .miso_i     (miso_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sck_o      (sck_o),
    .mosi_o     (mosi_o),
    .busy_res_o (busy_res_o),
    .done_res_o (done_res_o),
    .rx_byte_o  (rx_byte_o)
  );

  always #6 clk_i = ~clk_i;

  // engine model state
  spi_ms_pkg::cfg_t cfg_mirror;
  logic [NBITS-1:0] shift_bits;
  int unsigned      edge_num;
  logic [6:0]       tick_div;
  logic             clk_phase;
  logic             busy_st;
  logic             done_st;
  logic [NBITS-1:0] rx_hold;
  logic             miso_latch;

  spi_req_t         request_q[$];
  spi_ms_pkg::res_t expected_pin_q[$];
  spi_req_t         in_flight;
  int       queued_cnt = 0;
  int       fail_count = 0;
  int       cycle_cnt = 0;
  bit       gaps_on = 1'b1;
  bit       stalls_on = 1'b1;
  int       gap_left = 0;
  int       stall_left = 0;

  function automatic int half_period(input logic [2:0] dlog2);
    int k;
    k = (dlog2 == 3'd0) ? 1 : int'(dlog2);
    return 1 << (k - 1);
  endfunction

  function automatic void shift_sample_in();
    if (cfg_mirror.lsb_first) shift_bits = {miso_latch, shift_bits[NBITS-1:1]};
    else shift_bits = {shift_bits[NBITS-2:0], miso_latch};
  endfunction

  function automatic void base_tick(input logic miso);
    bit leading;
    if (!busy_st) return;
    tick_div = tick_div + 7'd1;
    if (int'(tick_div) < half_period(cfg_mirror.divide_log2)) return;
    tick_div = '0;
    clk_phase = ~clk_phase;
    edge_num++;
    leading = edge_num[0];
    if (!cfg_mirror.mode[0]) begin
      if (leading) miso_latch = miso;
      else shift_sample_in();
    end else begin
      if (leading) begin
        if (edge_num > 1) shift_sample_in();
      end else begin
        miso_latch = miso;
      end
    end
    if (edge_num >= 2 * NBITS) begin
      // cpha 1 still holds the last sample
      if (cfg_mirror.mode[0]) shift_sample_in();
      rx_hold = shift_bits;
      done_st = 1'b1;
      busy_st = 1'b0;
      edge_num = 0;
      tick_div = '0;
      clk_phase = 1'b0;
    end
  endfunction

  function automatic spi_ms_pkg::res_t advance_engine(input spi_req_t r);
    spi_ms_pkg::res_t pins;
    case (r.req)
      spi_ms_pkg::REQ_TICK: base_tick(r.miso);
      spi_ms_pkg::REQ_LOAD: begin
        if (!busy_st) begin
          shift_bits = NBITS'(r.tx);
          busy_st = 1'b1;
          edge_num = 0;
          tick_div = '0;
          clk_phase = 1'b0;
          miso_latch = 1'b0;
        end
      end
      spi_ms_pkg::REQ_READ: done_st = 1'b0;
      default: ;
    endcase
    pins.sck = clk_phase ^ cfg_mirror.mode[1];
    pins.mosi = cfg_mirror.lsb_first ? shift_bits[0] : shift_bits[NBITS-1];
    pins.busy = busy_st;
    pins.done = done_st;
    pins.rx_byte = rx_hold[7:0];
    return pins;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) expected_pin_q.push_back(advance_engine(in_flight));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_flight = request_q.pop_front();
          req_type_i <= in_flight.req;
          tx_byte_i <= in_flight.tx;
          miso_i <= in_flight.miso;
          in_valid_i <= 1'b1;
          gap_left <= gaps_on ? $urandom_range(0, 8) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic compare_pin(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
    end
  endtask

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    spi_ms_pkg::res_t want;
    int   n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pin_q.size() == 0) begin
          fail_count++;
          $error("result transfer with nothing expected");
        end else begin
          want = expected_pin_q.pop_front();
          compare_pin("sck", want.sck, sck_o);
          compare_pin("mosi", want.mosi, mosi_o);
          compare_pin("busy_res", want.busy, busy_res_o);
          compare_pin("done_res", want.done, done_res_o);
          compare_pin("rx_byte", want.rx_byte, rx_byte_o);
        end
        n = stalls_on ? $urandom_range(0, 8) : 0;
        stall_left <= n;
        out_ready_i <= (n == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= (stall_left == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("spi_master_shifter_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] req, input logic [7:0] tx, input logic miso);
    spi_req_t r;
    r.req = req;
    r.tx = tx;
    r.miso = miso;
    request_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || expected_pin_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [spi_ms_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [spi_ms_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      spi_ms_pkg::CFG_DIVIDE: cfg_mirror.divide_log2 = val;
      spi_ms_pkg::CFG_MODE:   cfg_mirror.mode = val[1:0];
      spi_ms_pkg::CFG_ORDER:  cfg_mirror.lsb_first = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int dlog2, input int mode, input int lsb);
    drain();
    write_reg(spi_ms_pkg::CFG_DIVIDE, spi_ms_pkg::CFG_DATA_W'(dlog2));
    write_reg(spi_ms_pkg::CFG_MODE, spi_ms_pkg::CFG_DATA_W'(mode));
    write_reg(spi_ms_pkg::CFG_ORDER, spi_ms_pkg::CFG_DATA_W'(lsb));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gaps_on = ($urandom_range(0, 2) != 0);
    stalls_on = ($urandom_range(0, 2) != 0);
  endtask

  // load, enough ticks for the whole frame, then usually a read;
  // some frames are cut short or carry stray requests
  task automatic queue_frame(input int half, input bit may_break);
    int n_ticks;
    push_req(spi_ms_pkg::REQ_LOAD, 8'($urandom), 1'($urandom));
    n_ticks = 2 * NBITS * half + $urandom_range(0, 3);
    if (may_break && $urandom_range(0, 9) == 0) n_ticks = $urandom_range(0, 2 * NBITS * half);
    for (int i = 0; i < n_ticks; i++) begin
      if (may_break && $urandom_range(0, 19) == 0)
        push_req(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      push_req(spi_ms_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 4) != 0)
      push_req(spi_ms_pkg::REQ_READ, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int phase_div[6];
    int phase_mode[6];
    int phase_lsb[6];
    int start_cnt;
    cfg_mirror.divide_log2 = spi_ms_pkg::DIVIDE_RESET;
    cfg_mirror.mode = 2'd0;
    cfg_mirror.lsb_first = 1'b0;
    shift_bits = '0;
    edge_num = 0;
    tick_div = '0;
    clk_phase = 1'b0;
    busy_st = 1'b0;
    done_st = 1'b0;
    rx_hold = '0;
    miso_latch = 1'b0;
    phase_div = '{1, 2, 3, 1, 4, 2};
    phase_mode = '{0, 1, 2, 3, 3, 0};
    phase_lsb = '{0, 1, 0, 1, 0, 1};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle requests, extreme bytes, busy load, load with done set
    set_config(1, 0, 0);
    push_req(spi_ms_pkg::REQ_TICK, 8'hFF, 1'b1);
    push_req(REQ_UNUSED, 8'hFF, 1'b1);
    push_req(spi_ms_pkg::REQ_READ, 8'h00, 1'b0);
    push_req(spi_ms_pkg::REQ_LOAD, 8'hFF, 1'b0);
    push_req(spi_ms_pkg::REQ_LOAD, 8'h00, 1'b1);
    for (int i = 0; i < 2 * NBITS; i++) push_req(spi_ms_pkg::REQ_TICK, 8'h00, 1'(i >> 1));
    push_req(spi_ms_pkg::REQ_LOAD, 8'h5A, 1'b0);
    for (int i = 0; i < 4; i++) push_req(spi_ms_pkg::REQ_TICK, 8'hA5, 1'b1);
    push_req(spi_ms_pkg::REQ_READ, 8'h00, 1'b0);

    // settings change mid-transfer, divide zero acts as one
    set_config(0, 3, 1);
    for (int i = 0; i < 2 * NBITS; i++)
      push_req(spi_ms_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
    push_req(spi_ms_pkg::REQ_READ, 8'($urandom), 1'b0);

    for (int p = 0; p < 6; p++) begin
      set_config(phase_div[p], phase_mode[p], phase_lsb[p]);
      start_cnt = queued_cnt;
      while (queued_cnt - start_cnt < 110) begin
        if ($urandom_range(0, 9) < 8)
          queue_frame(half_period(3'(phase_div[p])), 1'b1);
        else
          push_req(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end
    end

    // slowest clock: one complete frame
    set_config(7, 1, 0);
    queue_frame(half_period(3'd7), 1'b0);
    push_req(spi_ms_pkg::REQ_READ, 8'($urandom), 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("spi_master_shifter_unit_tb OK");
    end else begin
      $display("spi_master_shifter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
